@@ hdl/sevq_pkg.sv @@
// Shared types and codes for the sorted event queue.
`timescale 1ns / 1ps
package sevq_pkg;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      logic insert;
      logic remove;
   } cell_cmd_type;

endpackage

@@ hdl/sevq_if.sv @@
// Valid/ready channel interfaces for requests and responses.
`timescale 1ns / 1ps
interface sevq_req_if #(
   parameter int TIME_BITS = 32,
   parameter int TAG_BITS  = 8
);
   logic                 valid;
   logic                 ready;
   logic                 operation;
   logic [TIME_BITS-1:0] event_time;
   logic [TAG_BITS-1:0]  event_tag;

   modport source (output valid, operation, event_time, event_tag, input ready);
   modport sink   (input valid, operation, event_time, event_tag, output ready);
endinterface

interface sevq_rsp_if #(
   parameter int TIME_BITS = 32,
   parameter int TAG_BITS  = 8,
   parameter int CNT_BITS  = 5
);
   logic                 valid;
   logic                 ready;
   logic [1:0]           status;
   logic [TIME_BITS-1:0] popped_time;
   logic [TAG_BITS-1:0]  popped_tag;
   logic                 head_valid;
   logic [TIME_BITS-1:0] head_time;
   logic [TAG_BITS-1:0]  head_tag;
   logic [CNT_BITS-1:0]  entry_count;

   modport source (output valid, status, popped_time, popped_tag, head_valid,
                   head_time, head_tag, entry_count, input ready);
   modport sink   (input valid, status, popped_time, popped_tag, head_valid,
                   head_time, head_tag, entry_count, output ready);
endinterface

@@ hdl/sevq_cell.sv @@
// One slot of the sorted shift-register queue.
`timescale 1ns / 1ps
module sevq_cell #(
   parameter int TIME_BITS = 32,
   parameter int TAG_BITS  = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sevq_pkg::cell_cmd_type cmd,
   input  logic [TIME_BITS-1:0]  new_time,
   input  logic [TAG_BITS-1:0]   new_tag,
   input  logic                  prev_keep,
   input  logic                  prev_valid,
   input  logic [TIME_BITS-1:0]  prev_time,
   input  logic [TAG_BITS-1:0]   prev_tag,
   input  logic                  next_valid,
   input  logic [TIME_BITS-1:0]  next_time,
   input  logic [TAG_BITS-1:0]   next_tag,
   output logic                  keep,
   output logic                  valid,
   output logic [TIME_BITS-1:0]  slot_time,
   output logic [TAG_BITS-1:0]   slot_tag
);
   import sevq_pkg::*;

   logic                 valid_ff, valid_in;
   logic [TIME_BITS-1:0] time_ff, time_in;
   logic [TAG_BITS-1:0]  tag_ff, tag_in;

   // entry stays put on insert when it sorts at or before the new one
   assign keep = valid_ff && (time_ff <= new_time);

   always_comb begin
      valid_in = valid_ff;
      time_in  = time_ff;
      tag_in   = tag_ff;
      if (cmd.insert && !keep) begin
         if (prev_keep) begin
            valid_in = 1'b1;
            time_in  = new_time;
            tag_in   = new_tag;
         end else begin
            valid_in = prev_valid;
            time_in  = prev_time;
            tag_in   = prev_tag;
         end
      end else if (cmd.remove) begin
         valid_in = next_valid;
         time_in  = next_time;
         tag_in   = next_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      time_ff <= time_in;
      tag_ff  <= tag_in;
   end

   assign valid     = valid_ff;
   assign slot_time = time_ff;
   assign slot_tag  = tag_ff;

endmodule

@@ hdl/sorted_event_queue.sv @@
// Sorted event queue top level: cell chain, count and response register.
`timescale 1ns / 1ps
// Holds up to DEPTH (time, tag) entries in a row of cells, earliest in cell 0;
// equal times leave in arrival order. Every request beat yields one response
// beat with the status, the popped entry (zero on insert or error) and the new
// head and count. The cell chain shifts on the accept edge and the response
// register loads the new head on the next edge. A new request is not taken
// while one is in flight; it is taken in the cycle the previous response is
// consumed. No clearing pass after reset; the block is ready as soon as reset
// is released.
module sorted_event_queue #(
   parameter int DEPTH     = 16,
   parameter int TIME_BITS = 32,
   parameter int TAG_BITS  = 8,
   parameter int CNT_BITS  = $clog2(DEPTH + 1)
) (
   input logic clock,
   input logic reset,
   sevq_req_if.sink   req_bus,
   sevq_rsp_if.source rsp_bus
);
   import sevq_pkg::*;

   cell_cmd_type         cmd;
   logic                 req_fire;
   logic                 is_full, is_empty;

   logic [DEPTH-1:0]     cell_valid;
   logic [DEPTH-1:0]     cell_keep;
   logic [TIME_BITS-1:0] cell_time [DEPTH];
   logic [TAG_BITS-1:0]  cell_tag  [DEPTH];

   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 pend_ff;
   status_type           status_ff;
   logic [TIME_BITS-1:0] popped_time_ff;
   logic [TAG_BITS-1:0]  popped_tag_ff;
   logic                 rsp_valid_ff;
   logic [1:0]           rsp_status_ff;
   logic [TIME_BITS-1:0] rsp_popped_time_ff;
   logic [TAG_BITS-1:0]  rsp_popped_tag_ff;
   logic                 rsp_head_valid_ff;
   logic [TIME_BITS-1:0] rsp_head_time_ff;
   logic [TAG_BITS-1:0]  rsp_head_tag_ff;
   logic [CNT_BITS-1:0]  rsp_count_ff;

   assign is_full  = (count_ff == CNT_BITS'(DEPTH));
   assign is_empty = (count_ff == '0);

   assign req_bus.ready = !pend_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign cmd.insert = req_fire && (req_bus.operation == OP_INSERT) && !is_full;
   assign cmd.remove = req_fire && (req_bus.operation == OP_REMOVE) && !is_empty;

   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (cmd.remove) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                 p_keep, p_valid, n_valid;
      logic [TIME_BITS-1:0] p_time, n_time;
      logic [TAG_BITS-1:0]  p_tag, n_tag;

      if (i == 0) begin : g_first
         assign p_keep  = 1'b1;
         assign p_valid = 1'b0;
         assign p_time  = '0;
         assign p_tag   = '0;
      end else begin : g_mid
         assign p_keep  = cell_keep[i-1];
         assign p_valid = cell_valid[i-1];
         assign p_time  = cell_time[i-1];
         assign p_tag   = cell_tag[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign n_valid = 1'b0;
         assign n_time  = '0;
         assign n_tag   = '0;
      end else begin : g_inner
         assign n_valid = cell_valid[i+1];
         assign n_time  = cell_time[i+1];
         assign n_tag   = cell_tag[i+1];
      end

      sevq_cell #(
         .TIME_BITS (TIME_BITS),
         .TAG_BITS  (TAG_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .new_time   (req_bus.event_time),
         .new_tag    (req_bus.event_tag),
         .prev_keep  (p_keep),
         .prev_valid (p_valid),
         .prev_time  (p_time),
         .prev_tag   (p_tag),
         .next_valid (n_valid),
         .next_time  (n_time),
         .next_tag   (n_tag),
         .keep       (cell_keep[i]),
         .valid      (cell_valid[i]),
         .slot_time  (cell_time[i]),
         .slot_tag   (cell_tag[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         pend_ff  <= req_fire;
         if (pend_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (req_fire) begin
         status_ff      <= STATUS_OK;
         popped_time_ff <= '0;
         popped_tag_ff  <= '0;
         if (req_bus.operation == OP_INSERT) begin
            if (is_full) begin
               status_ff <= STATUS_FULL;
            end
         end else if (is_empty) begin
            status_ff <= STATUS_EMPTY;
         end else begin
            popped_time_ff <= cell_time[0];
            popped_tag_ff  <= cell_tag[0];
         end
      end

      // chain has settled by the edge after the accept
      if (pend_ff) begin
         rsp_status_ff      <= status_ff;
         rsp_popped_time_ff <= popped_time_ff;
         rsp_popped_tag_ff  <= popped_tag_ff;
         rsp_head_valid_ff  <= cell_valid[0];
         rsp_head_time_ff   <= cell_valid[0] ? cell_time[0] : '0;
         rsp_head_tag_ff    <= cell_valid[0] ? cell_tag[0] : '0;
         rsp_count_ff       <= count_ff;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.popped_time = rsp_popped_time_ff;
   assign rsp_bus.popped_tag  = rsp_popped_tag_ff;
   assign rsp_bus.head_valid  = rsp_head_valid_ff;
   assign rsp_bus.head_time   = rsp_head_time_ff;
   assign rsp_bus.head_tag    = rsp_head_tag_ff;
   assign rsp_bus.entry_count = rsp_count_ff;

   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == int'(count_ff))
      else $error("occupancy count disagrees with valid cells");

   a_cells_packed: assert property (@(posedge clock) disable iff (reset)
      (cell_valid & (cell_valid + DEPTH'(1))) == '0)
      else $error("valid cells are not packed toward the head");

   a_head_ordered: assert property (@(posedge clock) disable iff (reset)
      cell_valid[1] |-> (cell_time[0] <= cell_time[1]))
      else $error("head entry is later than its successor");

   a_accept_then_response: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (pend_ff && !req_bus.ready) ##1 rsp_valid_ff)
      else $error("accepted beat did not produce a response");

endmodule
